// ===== design/rl2n_pkg.sv =====
// ----------------------------------------------------------------------------
// rl2n_pkg: shared widths, codes and types of the relative L2 change norm
// Field widths, configuration register codes and the request/response types
// passed between the accumulator and the ratio unit.
// ----------------------------------------------------------------------------
package rl2n_pkg;

	localparam int VALUE_W   = 24;               // signed Q8.16 input value
	localparam int GROUP_W   = 6;                // energy group index
	localparam int IN_DATA_W = 2 * VALUE_W;      // new_value, old_value
	localparam int SUM_W     = 63;               // Q31.32 saturating sums
	localparam int MAG_W     = VALUE_W + 1;      // magnitude of a difference
	localparam int PROD_W    = 2 * MAG_W - 1;    // squares stay below 2^48
	localparam int RATIO_W   = 32;               // unsigned Q16.16 result
	localparam int CFG_IDX_W = 1;
	localparam int MAX_GROUPS = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GROUP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_GROUP = 1'd1;

	typedef struct packed {
		logic [SUM_W-1:0] diff_sum;
		logic [SUM_W-1:0] ref_sum;
	} ratio_req_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               zero_ref;
	} ratio_rsp_t;

endpackage

// ===== design/rl2n_ratio.sv =====
// ----------------------------------------------------------------------------
// rl2n_ratio: bit-serial scaled divide and integer square root
// Forms floor(sqrt(diff * 2^32 / ref)) one quotient bit, then one root bit,
// per cycle; flags a zero reference and saturates an oversized ratio.
// ----------------------------------------------------------------------------
module rl2n_ratio (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  rl2n_pkg::ratio_req_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rl2n_pkg::ratio_rsp_t  rsp
);

	localparam int SUM_W  = rl2n_pkg::SUM_W;
	localparam int NUM_W  = SUM_W + rl2n_pkg::RATIO_W;
	localparam int QUO_W  = SUM_W + 1;
	localparam int STEP_W = $clog2(NUM_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
	localparam logic [QUO_W-1:0]  BIT_INIT  = {2'b01, {(QUO_W-2){1'b0}}};

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_DIV  = 2'd1;
	localparam logic [1:0] R_SQRT = 2'd2;
	localparam logic [1:0] R_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [NUM_W-1:0]   num_q;
	logic [SUM_W-1:0]   den_q;
	logic [SUM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;     // quotient, then the radicand
	logic [QUO_W-1:0]   res_q;
	logic [QUO_W-1:0]   bit_q;
	logic [STEP_W-1:0]  step_q;
	rl2n_pkg::ratio_rsp_t rsp_q;

	logic [QUO_W-1:0] rem_sh;
	logic [QUO_W-1:0] den_ext;
	logic             div_ge;
	logic [QUO_W-1:0] rem_sub;
	logic [QUO_W-1:0] trial;
	logic             sq_ge;
	logic [QUO_W-1:0] res_next;
	logic             too_big;

	assign req_ready = (state_q == R_IDLE);
	assign rsp_valid = (state_q == R_DONE);
	assign rsp       = rsp_q;

	// restoring division step
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign den_ext = {1'b0, den_q};
	assign div_ge  = (rem_sh >= den_ext);
	assign rem_sub = rem_sh - den_ext;

	// root step: res and bit never overlap, so OR stands for the add
	assign trial    = res_q | bit_q;
	assign sq_ge    = (quo_q >= trial);
	assign res_next = sq_ge ? ((res_q >> 1) | bit_q) : (res_q >> 1);

	assign too_big = ({{(SUM_W-31){1'b0}}, req.diff_sum[SUM_W-1:32]} >= req.ref_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (req_valid) begin
						if (req.ref_sum == '0 || too_big) begin
							state_q <= R_DONE;
						end else begin
							state_q <= R_DIV;
						end
					end
				end
				R_DIV: begin
					if (step_q == '0) begin
						state_q <= R_SQRT;
					end
				end
				R_SQRT: begin
					if (bit_q[0]) begin
						state_q <= R_DONE;
					end
				end
				R_DONE: begin
					if (rsp_ready) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				num_q  <= {req.diff_sum, {rl2n_pkg::RATIO_W{1'b0}}};
				den_q  <= req.ref_sum;
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= STEP_LAST;
				rsp_q.ratio    <= '1;
				rsp_q.zero_ref <= (req.ref_sum == '0);
			end
			R_DIV: begin
				num_q  <= num_q << 1;
				rem_q  <= div_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], div_ge};
				step_q <= step_q - STEP_W'(1);
				res_q  <= '0;
				bit_q  <= BIT_INIT;
			end
			R_SQRT: begin
				if (sq_ge) begin
					quo_q <= quo_q - trial;
				end
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					rsp_q.ratio    <= res_next[rl2n_pkg::RATIO_W-1:0];
					rsp_q.zero_ref <= 1'b0;
				end
			end
			default: begin
				// hold the result until taken
			end
		endcase
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == R_DIV |-> rem_q < den_q)
		else $error("division remainder not below divisor");

	a_zero_ref: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.ref_sum == '0 |=>
		state_q == R_DONE && rsp_q.zero_ref && rsp_q.ratio == '1)
		else $error("zero reference not flagged");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == R_DONE && !rsp_ready |=> state_q == R_DONE && $stable(rsp_q))
		else $error("ratio response lost while waiting");

endmodule

// ===== design/relative_l2_change_norm.sv =====
// ----------------------------------------------------------------------------
// relative_l2_change_norm: relative L2 norm of the change between iterates
// Accumulates saturating sums of (new - old)^2 and new^2 over the counted
// energy groups and, on the last item of a vector, returns
// sqrt(diff_sum / ref_sum) as unsigned Q16.16.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Handshake                  Payload
// s_axis     in   s_axis_tvalid/tready       tdata: new_value, old_value
//                                            tuser: group_index, tlast: last_item
// m_axis     out  m_axis_tvalid/tready       tdata: change_ratio
//                                            tuser: zero_reference
// cfg        in   cfg_valid/cfg_ready        cfg_index, cfg_data (group bounds)
//
// Both squares of an input request are formed by one shift-and-add multiplier
// that consumes one multiplier bit per cycle, for as many bits as the larger
// of |new - old| and |new| has (at most 24).
// The last item hands the sums to the ratio unit, which divides and then takes
// the square root; the next vector accumulates meanwhile.
// Reset clears the sums, the group bounds (0 and 63) and all valid flags.
// A stalled result waits in the output register and a second one in the
// ratio unit; a further last item then holds the input until the output drains.
//
module relative_l2_change_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [23:0] new_value, [47:24] old_value
	input  logic [rl2n_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [5:0] group_index
	input  logic [rl2n_pkg::GROUP_W-1:0]        s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] change_ratio
	output logic [rl2n_pkg::RATIO_W-1:0]        m_axis_tdata,
	// [0] zero_reference
	output logic [0:0]                          m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rl2n_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rl2n_pkg::GROUP_W-1:0]        cfg_data
);

	localparam int VALUE_W = rl2n_pkg::VALUE_W;
	localparam int MAG_W   = rl2n_pkg::MAG_W;
	localparam int PROD_W  = rl2n_pkg::PROD_W;
	localparam int SUM_W   = rl2n_pkg::SUM_W;
	localparam int GROUP_W = rl2n_pkg::GROUP_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_MUL  = 1'b1;

	// saturating add of one partial product
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
	                                             input logic [PROD_W-1:0] term);
		logic [SUM_W:0] s;
		s = {1'b0, sum} + {{(SUM_W+1-PROD_W){1'b0}}, term};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	logic                state_q;
	logic [GROUP_W-1:0]  first_group_q;
	logic [GROUP_W-1:0]  final_group_q;
	logic [SUM_W-1:0]    diff_sum_q;
	logic [SUM_W-1:0]    ref_sum_q;
	logic [PROD_W-1:0]   mcand_d_q;
	logic [PROD_W-1:0]   mcand_r_q;
	logic [MAG_W-1:0]    mplr_d_q;
	logic [MAG_W-1:0]    mplr_r_q;
	logic                last_q;
	logic                out_valid_q;
	logic [rl2n_pkg::RATIO_W-1:0] out_ratio_q;
	logic                out_zref_q;

	logic signed [MAG_W-1:0] new_ext;
	logic signed [MAG_W-1:0] old_ext;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        mag_d;
	logic [MAG_W-1:0]        mag_n;
	logic                    counted;
	logic                    in_accept;
	logic                    mul_done;
	logic                    launch;
	logic                    req_ready;
	logic                    rsp_valid;
	logic                    rsp_ready;
	rl2n_pkg::ratio_req_t    req;
	rl2n_pkg::ratio_rsp_t    rsp;

	// ---------------------------------------------------------------- input
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign new_ext = {s_axis_tdata[VALUE_W-1], s_axis_tdata[VALUE_W-1:0]};
	assign old_ext = {s_axis_tdata[2*VALUE_W-1], s_axis_tdata[2*VALUE_W-1:VALUE_W]};
	assign diff    = new_ext - old_ext;
	// magnitudes read as unsigned: a difference reaches at most 2^24 - 1
	assign mag_d   = diff[MAG_W-1] ? (-diff) : diff;
	assign mag_n   = new_ext[MAG_W-1] ? (-new_ext) : new_ext;

	assign counted = (s_axis_tuser >= first_group_q) && (s_axis_tuser <= final_group_q)
	              && ({1'b0, s_axis_tuser} < (GROUP_W+1)'(rl2n_pkg::MAX_GROUPS));

	// ------------------------------------------------------------ multiplier
	// Both squares run as one shift-and-add pass; done once no multiplier
	// bit is left. An item outside the group range loads zeros and finishes
	// at once.
	assign mul_done = (mplr_d_q == '0) && (mplr_r_q == '0);
	assign launch   = (state_q == ST_MUL) && mul_done && last_q && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// a last item waits here until the ratio unit is free
					if (mul_done && (!last_q || req_ready)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mcand_d_q <= counted ? {{(PROD_W-MAG_W){1'b0}}, mag_d} : '0;
			mcand_r_q <= counted ? {{(PROD_W-MAG_W){1'b0}}, mag_n} : '0;
			mplr_d_q  <= counted ? mag_d : '0;
			mplr_r_q  <= counted ? mag_n : '0;
			last_q    <= s_axis_tlast;
		end else if (state_q == ST_MUL && !mul_done) begin
			// advance one multiplier bit
			mcand_d_q <= mcand_d_q << 1;
			mcand_r_q <= mcand_r_q << 1;
			mplr_d_q  <= mplr_d_q >> 1;
			mplr_r_q  <= mplr_r_q >> 1;
		end
	end

	// ------------------------------------------------------------------ sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_sum_q <= '0;
			ref_sum_q  <= '0;
		end else if (launch) begin
			// the ratio unit has taken the sums; start the next vector at zero
			diff_sum_q <= '0;
			ref_sum_q  <= '0;
		end else if (state_q == ST_MUL && !mul_done) begin
			diff_sum_q <= sat_add(diff_sum_q, mplr_d_q[0] ? mcand_d_q : '0);
			ref_sum_q  <= sat_add(ref_sum_q, mplr_r_q[0] ? mcand_r_q : '0);
		end
	end

	// --------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_group_q <= '0;
			final_group_q <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rl2n_pkg::CFG_FIRST_GROUP: first_group_q <= cfg_data;
				rl2n_pkg::CFG_FINAL_GROUP: final_group_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------ ratio unit
	assign req.diff_sum = diff_sum_q;
	assign req.ref_sum  = ref_sum_q;

	rl2n_ratio u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (launch),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// --------------------------------------------------------- output stage
	// Load a finished ratio whenever the output register is empty or
	// being drained in this cycle.
	assign rsp_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_ratio_q <= rsp.ratio;
			out_zref_q  <= rsp.zero_ref;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_ratio_q;
	assign m_axis_tuser[0] = out_zref_q;

	// ------------------------------------------------------------ assertions
	a_clear_on_launch: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> diff_sum_q == '0 && ref_sum_q == '0)
		else $error("sums not cleared after handing off a vector");

	a_zero_ref_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '1)
		else $error("zero reference result without saturated ratio");

	a_mplr_shift: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && !mul_done |=> mplr_d_q == ($past(mplr_d_q) >> 1))
		else $error("multiplier did not advance one bit");

endmodule
